### rtl/ecpr_pkg.sv
package ecpr_pkg;

  localparam int unsigned DefNumFrames = 64;
  localparam int unsigned DefNumPages  = 1024;

  localparam int unsigned CfgW    = 7;
  localparam int unsigned StatusW = 3;
  localparam int unsigned FrameW  = 6;
  localparam int unsigned PageW   = 10;

  typedef enum logic [StatusW-1:0] {
    ST_HIT      = 3'd0,
    ST_FAULT    = 3'd1,
    ST_EVICT    = 3'd2,
    ST_RELEASED = 3'd3,
    ST_NOT_RES  = 3'd4
  } status_e;

  localparam logic CMD_REF = 1'b0;
  localparam logic CMD_REL = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PLOOK,
    S_DECIDE,
    S_FREE_RD,
    S_FREE_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_EV_RD,
    S_EV_CHK,
    S_FINISH
  } state_e;

endpackage

### rtl/ecpr_page_mem.sv
module ecpr_page_mem #(
  parameter int unsigned NumPages = ecpr_pkg::DefNumPages,
  parameter int unsigned FrameIdxW = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [$clog2(NumPages)-1:0] rd_addr_i,
  output logic                        rd_res_o,
  output logic [FrameIdxW-1:0]        rd_frame_o,
  input  logic                        wr_en_i,
  input  logic [$clog2(NumPages)-1:0] wr_addr_i,
  input  logic                        wr_res_i,
  input  logic [FrameIdxW-1:0]        wr_frame_i,
  output logic                        clr_busy_o
);
  import ecpr_pkg::*;

  localparam int unsigned AW = $clog2(NumPages);

  logic [FrameIdxW:0] mem_q [NumPages];
  logic [FrameIdxW:0] rd_q;
  logic [AW:0]        clr_q, clr_d;

  // Resident bit lives in the top bit; clearing pass after reset wipes it.
  assign clr_busy_o = ~clr_q[AW];
  assign clr_d = clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_busy_o) begin
      clr_q <= (clr_q[AW-1:0] == AW'(NumPages - 1)) ? {1'b1, {AW{1'b0}}} : clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      mem_q[clr_q[AW-1:0]] <= '0;
    end else if (wr_en_i) begin
      mem_q[wr_addr_i] <= {wr_res_i, wr_frame_i};
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_res_o   = rd_q[FrameIdxW];
  assign rd_frame_o = rd_q[FrameIdxW-1:0];

endmodule

### rtl/ecpr_frame_mem.sv
module ecpr_frame_mem #(
  parameter int unsigned NumFrames = ecpr_pkg::DefNumFrames,
  parameter int unsigned PageIdxW  = 10
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [$clog2(NumFrames)-1:0] rd_addr_i,
  output logic                         rd_occ_o,
  output logic                         rd_use_o,
  output logic                         rd_dirty_o,
  output logic [PageIdxW-1:0]          rd_owner_o,
  input  logic                         wr_en_i,
  input  logic [$clog2(NumFrames)-1:0] wr_addr_i,
  input  logic                         wr_occ_i,
  input  logic                         wr_use_i,
  input  logic                         wr_dirty_i,
  input  logic                         wr_owner_en_i,
  input  logic [PageIdxW-1:0]          wr_owner_i,
  output logic                         clr_busy_o
);
  import ecpr_pkg::*;

  localparam int unsigned AW = $clog2(NumFrames);

  logic [2:0]          flags_q [NumFrames];
  logic [PageIdxW-1:0] owner_q [NumFrames];
  logic [2:0]          flags_rd_q;
  logic [PageIdxW-1:0] owner_rd_q;
  logic [AW:0]         clr_q, clr_d;

  assign clr_busy_o = ~clr_q[AW];
  assign clr_d = clr_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (clr_busy_o) begin
      clr_q <= (clr_q[AW-1:0] == AW'(NumFrames - 1)) ? {1'b1, {AW{1'b0}}} : clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      flags_q[clr_q[AW-1:0]] <= '0;
    end else if (wr_en_i) begin
      flags_q[wr_addr_i] <= {wr_occ_i, wr_use_i, wr_dirty_i};
    end
    if (!clr_busy_o && wr_en_i && wr_owner_en_i) begin
      owner_q[wr_addr_i] <= wr_owner_i;
    end
    flags_rd_q <= flags_q[rd_addr_i];
    owner_rd_q <= owner_q[rd_addr_i];
  end

  assign rd_occ_o   = flags_rd_q[2];
  assign rd_use_o   = flags_rd_q[1];
  assign rd_dirty_o = flags_rd_q[0];
  assign rd_owner_o = owner_rd_q;

endmodule

### rtl/enhanced_clock_page_replacer.sv
// Page replacer with enhanced second-chance clock. A hit or release of a resident
// page keeps busy high through S_PLOOK, S_DECIDE, S_EV_RD, S_EV_CHK and S_FINISH,
// and the result appears in the cycle after; a release of a nonresident page keeps
// busy high through S_PLOOK, S_DECIDE and S_FINISH. A fault reads the frame table
// one frame at a time, in a read state and a check state, to find the lowest free
// frame (up to N frames), then, if none, the clock scan does the same for up to 4*N
// frames (N = frames in use); the single-port read-modify-write of the frame
// memory sets this. After reset a clearing pass over every page and frame entry
// runs with busy high. Results appear for one cycle on done_o and cannot be stalled.
module enhanced_clock_page_replacer #(
  parameter int unsigned NUM_FRAMES = ecpr_pkg::DefNumFrames,
  parameter int unsigned NUM_PAGES  = ecpr_pkg::DefNumPages
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ecpr_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         start,
  output logic                         busy,
  input  logic                         command_i,
  input  logic [ecpr_pkg::PageW-1:0]   page_id_i,
  input  logic                         is_write_i,
  output logic                         done_o,
  output logic [ecpr_pkg::StatusW-1:0] status_o,
  output logic [ecpr_pkg::FrameW-1:0]  frame_index_o,
  output logic [ecpr_pkg::PageW-1:0]   evicted_page_o,
  output logic                         evicted_dirty_o
);
  import ecpr_pkg::*;

  localparam int unsigned FA = $clog2(NUM_FRAMES);
  localparam int unsigned PA = $clog2(NUM_PAGES);
  localparam int unsigned CW = $clog2(4 * NUM_FRAMES + 1);

  state_e state_q, state_d;

  logic [CfgW-1:0] cfg_q;
  logic [FA:0]     n_act;
  logic [FA-1:0]   hand_q, hand_d;
  logic [FA-1:0]   f_q, f_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [FA-1:0]   pos_q, pos_d;
  logic            pass_q, pass_d;
  logic            cmd_q, wr_q;
  logic [PA-1:0]   page_q;
  logic [StatusW-1:0] st_q, st_d;
  logic [FA-1:0]   fr_q, fr_d;
  logic [PageW-1:0] evp_q, evp_d;
  logic            evd_q, evd_d;
  logic            done_q, done_d;

  logic [PA-1:0] p_rd_addr, p_wr_addr;
  logic          p_res, p_wr_en, p_wr_res, p_clr;
  logic [FA-1:0] p_frame, p_wr_frame;
  logic [FA-1:0] f_rd_addr, f_wr_addr;
  logic          f_occ, f_use, f_dirty, f_clr;
  logic [PA-1:0] f_owner, f_wr_owner;
  logic          f_wr_en, f_wr_occ, f_wr_use, f_wr_dirty, f_wr_owner_en;
  logic [FA-1:0] f_next;
  logic          pass_two;

  always_comb begin
    n_act = (FA+1)'(NUM_FRAMES);
    if (cfg_q == '0) begin
      n_act = (FA+1)'(1);
    end else if (32'(cfg_q) < NUM_FRAMES) begin
      n_act = (FA+1)'(cfg_q);
    end
  end

  assign f_next   = (32'(f_q) + 1 >= 32'(n_act)) ? '0 : f_q + 1'b1;
  // Pass bit flips every N steps; four passes bound the scan.
  assign pass_two = pass_q;

  ecpr_page_mem #(.NumPages(NUM_PAGES), .FrameIdxW(FA)) u_page (
    .clk_i, .rst_ni,
    .rd_addr_i(p_rd_addr), .rd_res_o(p_res), .rd_frame_o(p_frame),
    .wr_en_i(p_wr_en), .wr_addr_i(p_wr_addr), .wr_res_i(p_wr_res),
    .wr_frame_i(p_wr_frame), .clr_busy_o(p_clr)
  );

  ecpr_frame_mem #(.NumFrames(NUM_FRAMES), .PageIdxW(PA)) u_frame (
    .clk_i, .rst_ni,
    .rd_addr_i(f_rd_addr), .rd_occ_o(f_occ), .rd_use_o(f_use),
    .rd_dirty_o(f_dirty), .rd_owner_o(f_owner),
    .wr_en_i(f_wr_en), .wr_addr_i(f_wr_addr), .wr_occ_i(f_wr_occ),
    .wr_use_i(f_wr_use), .wr_dirty_i(f_wr_dirty),
    .wr_owner_en_i(f_wr_owner_en), .wr_owner_i(f_wr_owner), .clr_busy_o(f_clr)
  );

  assign busy        = (state_q != S_IDLE) || p_clr || f_clr;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cfg_q   <= CfgW'(64);
      hand_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hand_q  <= hand_d;
      done_q  <= done_d;
      if (cfg_valid_i) cfg_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      cmd_q  <= command_i;
      wr_q   <= is_write_i;
      page_q <= page_id_i[PA-1:0];
    end
    f_q    <= f_d;
    cnt_q  <= cnt_d;
    pos_q  <= pos_d;
    pass_q <= pass_d;
    st_q   <= st_d;
    fr_q   <= fr_d;
    evp_q  <= evp_d;
    evd_q  <= evd_d;
  end

  always_comb begin
    state_d = state_q;
    hand_d = hand_q;
    f_d = f_q;
    cnt_d = cnt_q;
    pos_d = pos_q;
    pass_d = pass_q;
    st_d = st_q;
    fr_d = fr_q;
    evp_d = evp_q;
    evd_d = evd_q;
    done_d = 1'b0;
    p_rd_addr = page_q;
    p_wr_en = 1'b0;
    p_wr_addr = page_q;
    p_wr_res = 1'b1;
    p_wr_frame = fr_q;
    f_rd_addr = f_q;
    f_wr_en = 1'b0;
    f_wr_addr = f_q;
    f_wr_occ = 1'b1;
    f_wr_use = 1'b1;
    f_wr_dirty = wr_q;
    f_wr_owner_en = 1'b0;
    f_wr_owner = page_q;
    case (state_q)
      S_IDLE: begin
        p_rd_addr = page_id_i[PA-1:0];
        if (start && !busy) state_d = S_PLOOK;
      end
      S_PLOOK: begin
        // Page entry read is in flight; fetch its frame next.
        state_d = S_DECIDE;
      end
      S_DECIDE: begin
        fr_d = p_frame;
        evp_d = '0;
        evd_d = 1'b0;
        if (p_res) begin
          f_d = p_frame;
          state_d = S_EV_RD;
        end else if (cmd_q == CMD_REL) begin
          st_d = ST_NOT_RES;
          fr_d = '0;
          state_d = S_FINISH;
        end else begin
          f_d = '0;
          state_d = S_FREE_RD;
        end
      end
      S_EV_RD: state_d = S_EV_CHK;
      S_EV_CHK: begin
        // Resident page: hit or release, rewrite the frame flags.
        f_wr_en = 1'b1;
        f_wr_addr = fr_q;
        if (cmd_q == CMD_REL) begin
          f_wr_occ = 1'b0;
          f_wr_use = 1'b0;
          f_wr_dirty = 1'b0;
          p_wr_en = 1'b1;
          p_wr_res = 1'b0;
          st_d = ST_RELEASED;
        end else begin
          f_wr_occ = f_occ;
          f_wr_dirty = f_dirty | wr_q;
          st_d = ST_HIT;
        end
        state_d = S_FINISH;
      end
      S_FREE_RD: state_d = S_FREE_CHK;
      S_FREE_CHK: begin
        if (!f_occ) begin
          fr_d = f_q;
          st_d = ST_FAULT;
          state_d = S_FINISH;
          f_wr_en = 1'b1;
          f_wr_owner_en = 1'b1;
          p_wr_en = 1'b1;
          p_wr_frame = f_q;
        end else if (32'(f_q) + 1 >= 32'(n_act)) begin
          f_d = (32'(hand_q) >= 32'(n_act)) ? '0 : hand_q;
          cnt_d = '0;
          pos_d = '0;
          pass_d = 1'b0;
          state_d = S_SCAN_RD;
        end else begin
          f_d = f_q + 1'b1;
          state_d = S_FREE_RD;
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CHK;
      S_SCAN_CHK: begin
        if (f_occ && !f_use && (pass_two || !f_dirty)) begin
          fr_d = f_q;
          hand_d = f_next;
          st_d = ST_EVICT;
          evp_d = PageW'(f_owner);
          evd_d = f_dirty;
          f_wr_en = 1'b1;
          f_wr_owner_en = 1'b1;
          p_wr_en = 1'b1;
          p_wr_addr = f_owner;
          p_wr_res = 1'b0;
          state_d = S_FINISH;
        end else begin
          if (pass_two && f_occ) begin
            f_wr_en = 1'b1;
            f_wr_occ = 1'b1;
            f_wr_use = 1'b0;
            f_wr_dirty = f_dirty;
          end
          f_d = f_next;
          cnt_d = cnt_q + 1'b1;
          if (32'(pos_q) + 1 >= 32'(n_act)) begin
            pos_d = '0;
            pass_d = ~pass_q;
          end else begin
            pos_d = pos_q + 1'b1;
          end
          state_d = S_SCAN_RD;
          if (cnt_q == CW'(4 * 32'(n_act) - 1)) begin
            // Unreachable with all frames occupied; give up at the hand.
            fr_d = f_next;
            hand_d = f_next;
            st_d = ST_EVICT;
            f_d = f_next;
            state_d = S_EV_RD;
          end
        end
      end
      S_FINISH: begin
        if (st_q == ST_EVICT || st_q == ST_FAULT) begin
          p_wr_en = 1'b1;
          p_wr_frame = fr_q;
        end
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign done_o          = done_q;
  assign status_o        = st_q;
  assign frame_index_o   = FrameW'(fr_q);
  assign evicted_page_o  = evp_q;
  assign evicted_dirty_o = evd_q;

  a_done_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> state_q == S_IDLE) else $error("done outside idle");
  a_hand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hand_q) < NUM_FRAMES) else $error("hand range");

endmodule
